// ===== design/channel_weighted_pixel_sum_unit_assert.svh =====
// Assertion macros for the channel weighted pixel sum unit.
`ifndef CHANNEL_WEIGHTED_PIXEL_SUM_UNIT_ASSERT_SVH
`define CHANNEL_WEIGHTED_PIXEL_SUM_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset.
`define CWPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwps: same-cycle check failed");

// Next-cycle implication, checked on clk outside reset.
`define CWPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwps: next-cycle check failed");

`endif

// ===== design/cwps_pkg.sv =====
// Package with sizes, codes and helper types of the channel weighted pixel sum unit.
`default_nettype none
package cwps_pkg;
  localparam int MAX_CHANNELS = 64;
  localparam int DATA_WIDTH   = 16;
  localparam int CH_W         = 6;
  localparam int CFG_W        = 7;
  localparam int ACC_W        = 40;
  localparam int PROD_W       = 2 * DATA_WIDTH;
  localparam int ADDR_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LIM_W        = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W        = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Per-beat control travelling with a sample through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } beat_ctrl_t;
endpackage
`default_nettype wire

// ===== design/cwps_stream_if.sv =====
// Stream interfaces for sample beats in and weighted sums out.
`default_nettype none
interface cwps_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic [cwps_pkg::CH_W-1:0]             channel_index;
  logic signed [cwps_pkg::DATA_WIDTH-1:0] value_word;

  modport source (output valid, output op, output channel_index, output value_word,
                  input ready);
  modport sink (input valid, input op, input channel_index, input value_word,
                output ready);
endinterface

interface cwps_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [cwps_pkg::ACC_W-1:0] weighted_sum;

  modport source (output valid, output weighted_sum, input ready);
  modport sink (input valid, input weighted_sum, output ready);
endinterface
`default_nettype wire

// ===== design/cwps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cwps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/channel_weighted_pixel_sum_unit.sv =====
// A beat's sum (last channel) passes stage 1, stage 2 and the result register.
// Throughput: one beat per cycle, loads and samples alike, unless a finished sum waits
// on the result side; set by the single multiply stage and the one 40-bit accumulate stage.
// Reset: clears pipeline valids, output valid and accumulator, sets channels_in_use to 64;
// the coefficient table is not cleared and holds nothing until loaded.
// Top level: coefficient table, multiply stage, accumulate stage and result register.
`default_nettype none
`include "channel_weighted_pixel_sum_unit_assert.svh"
module channel_weighted_pixel_sum_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cwps_pkg::CFG_W-1:0]    cfg_wr_data,
  cwps_sample_if.sink                        sample,
  cwps_result_if.source                      result
);
  logic [cwps_pkg::CFG_W-1:0]  channels_in_use;
  logic [cwps_pkg::CNT_W-1:0]  used;
  logic [cwps_pkg::CNT_W-1:0]  ch_wide;
  logic                        in_acc;
  logic                        keep;
  logic                        load_ok;

  cwps_pkg::beat_ctrl_t                   s1;
  logic signed [cwps_pkg::DATA_WIDTH-1:0] val1;
  logic [cwps_pkg::DATA_WIDTH-1:0]        coef1;
  cwps_pkg::beat_ctrl_t                   s2;
  logic signed [cwps_pkg::PROD_W-1:0]     prod2;
  logic [cwps_pkg::ACC_W-1:0]             acc;
  logic [cwps_pkg::ACC_W-1:0]             acc_next;
  logic                                   out_valid;
  logic [cwps_pkg::ACC_W-1:0]             out_sum;

  logic out_free;
  logic adv1;
  logic adv2;
  logic ready1;
  logic ready2;

  // Register above the table size acts as the table size.
  always_comb begin
    if (cwps_pkg::CNT_W'(channels_in_use) > cwps_pkg::CNT_W'(cwps_pkg::MAX_CHANNELS)) begin
      used = cwps_pkg::CNT_W'(cwps_pkg::MAX_CHANNELS);
    end else begin
      used = cwps_pkg::CNT_W'(channels_in_use);
    end
  end

  assign ch_wide = cwps_pkg::CNT_W'(sample.channel_index);
  assign in_acc  = sample.valid && sample.ready;
  assign keep    = (sample.op == cwps_pkg::OP_SAMPLE) && (ch_wide < used);
  assign load_ok = (sample.op == cwps_pkg::OP_LOAD) &&
                   (ch_wide < cwps_pkg::CNT_W'(cwps_pkg::MAX_CHANNELS));

  // Backpressure: only a finished sum waits on the result side.
  assign out_free = !out_valid || result.ready;
  assign adv2     = s2.valid && (!s2.last || out_free);
  assign ready2   = !s2.valid || adv2;
  assign adv1     = s1.valid && ready2;
  assign ready1   = !s1.valid || adv1;
  assign sample.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= cwps_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      channels_in_use <= cfg_wr_data;
    end
  end

  cwps_ram #(
    .WIDTH (cwps_pkg::DATA_WIDTH),
    .DEPTH (cwps_pkg::MAX_CHANNELS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (in_acc && load_ok),
    .waddr (cwps_pkg::ADDR_W'(sample.channel_index)),
    .wdata (sample.value_word),
    .re    (in_acc && keep),
    .raddr (cwps_pkg::ADDR_W'(sample.channel_index)),
    .rdata (coef1)
  );

  // Stage 1: sample beat alongside its coefficient read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (ready1) begin
      s1.valid <= in_acc && keep;
      s1.first <= (ch_wide == '0);
      s1.last  <= (ch_wide == used - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_acc && keep) begin
      val1 <= sample.value_word;
    end
  end

  // Stage 2: exact product.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (ready2) begin
      s2 <= adv1 ? s1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      prod2 <= $signed(coef1) * val1;
    end
  end

  // Stage 3: accumulate, restart on channel 0, capture on the last channel.
  always_comb begin
    if (s2.first) begin
      acc_next = cwps_pkg::ACC_W'(prod2);
    end else begin
      acc_next = acc + cwps_pkg::ACC_W'(prod2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv2) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2 && s2.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2.last) begin
      out_sum <= acc_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.weighted_sum = out_sum;

  `CWPS_ASSERT_NEXT(a_kept_sample_enters, in_acc && keep, s1.valid)
  `CWPS_ASSERT_NEXT(a_acc_holds_when_idle, !adv2, $stable(acc))
  `CWPS_ASSERT_NEXT(a_last_beat_held, s2.valid && s2.last && !out_free,
                    s2.valid && s2.last && $stable(prod2))
  `CWPS_ASSERT_NOW(a_stall_only_on_full_output, !sample.ready,
                   s1.valid && s2.valid && s2.last && out_valid)
endmodule
`default_nettype wire
